// ===== sv/tsac_pkg.sv =====
// Shared types, codes and constants of the TCP sender acknowledgement and congestion engine.
package tsac_pkg;

	// Operation codes carried by a request.
	typedef enum logic [1:0] {
		OP_OPEN    = 2'd0,
		OP_HEADER  = 2'd1,
		OP_TIMEOUT = 2'd2
	} tsac_op_t;

	// Register indexes on the configuration port.
	typedef enum logic [1:0] {
		REG_MSS      = 2'd0,
		REG_CWND     = 2'd1,
		REG_SSTHRESH = 2'd2
	} tsac_reg_t;

	localparam int PADDR_W = 4;

	localparam logic [15:0] MSS_RESET      = 16'd1400;
	localparam logic [31:0] CWND_RESET     = 32'd1400;
	localparam logic [31:0] SSTHRESH_RESET = 32'd65535;

	// Duplicate acknowledgement counting.
	localparam int          DUP_ACK_LIMIT_DEF = 3;
	localparam int          DUP_COUNT_W       = 2;
	localparam logic [DUP_COUNT_W-1:0] DUP_COUNT_MAX = 2'd3;

	typedef struct packed {
		logic [15:0] mss;
		logic [31:0] init_cwnd;
		logic [31:0] init_ssthresh;
	} tsac_cfg_t;

	typedef struct packed {
		logic [31:0]            next_seq;
		logic [31:0]            cwnd;
		logic [31:0]            ssthresh;
		logic [15:0]            win;
		logic [31:0]            last_good_ack;
		logic [DUP_COUNT_W-1:0] dup_count;
		logic [31:0]            last_header_ack;
		logic [15:0]            last_header_window;
	} tsac_state_t;

	typedef struct packed {
		logic [31:0] send_sequence;
		logic [31:0] congestion_window;
		logic [31:0] slow_start_threshold;
		logic [15:0] peer_window;
		logic        retransmit;
		logic [31:0] rewind_bytes;
		logic        zero_window;
	} tsac_result_t;

endpackage

// ===== sv/tcp_sender_ack_congestion.sv =====
// Top level of the TCP sender acknowledgement and congestion engine.
// One request (open, header, timeout or unused code) is accepted every cycle
// while the result buffer has space, and its result is registered into the
// result buffer on acceptance. The connection state updates from the request
// and the current state, and that state loop sets the rate of one request
// per clock. A two-entry result buffer holds results while the result side
// stalls, so the request side keeps accepting until both entries are full.
// Configuration is written through an APB port with registers at byte addresses
// 0 (MSS), 4 (initial congestion window) and 8 (initial slow start threshold).
module tcp_sender_ack_congestion #(
	parameter int DUP_ACK_LIMIT = tsac_pkg::DUP_ACK_LIMIT_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// Configuration port.
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [tsac_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	// Request channel.
	input  logic                         item_valid,
	output logic                         item_ready,
	input  logic [1:0]                   operation,
	input  logic [31:0]                  start_sequence,
	input  logic [31:0]                  ack_value,
	input  logic [15:0]                  peer_window_in,
	input  logic                         is_ack,
	// Result channel.
	output logic                         result_valid,
	input  logic                         result_ready,
	output logic [31:0]                  send_sequence,
	output logic [31:0]                  congestion_window,
	output logic [31:0]                  slow_start_threshold,
	output logic [15:0]                  peer_window,
	output logic                         retransmit,
	output logic [31:0]                  rewind_bytes,
	output logic                         zero_window
);
	import tsac_pkg::*;

	tsac_cfg_t    cfg;
	tsac_state_t  state_q;
	tsac_state_t  state_nxt;
	tsac_result_t res;
	tsac_result_t res_out;
	logic         space;
	logic         accept;

	assign item_ready = space;
	assign accept     = item_valid && space;

	tsac_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	tsac_update #(
		.DUP_ACK_LIMIT (DUP_ACK_LIMIT)
	) u_update (
		.st             (state_q),
		.cfg            (cfg),
		.operation      (operation),
		.start_sequence (start_sequence),
		.ack_value      (ack_value),
		.peer_window_in (peer_window_in),
		.is_ack         (is_ack),
		.nxt            (state_nxt),
		.res            (res)
	);

	// Connection state advances on every accepted request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (accept) begin
			state_q <= state_nxt;
		end
	end

	tsac_outbuf u_outbuf (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (accept),
		.push_data    (res),
		.space        (space),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result_data  (res_out)
	);

	assign send_sequence        = res_out.send_sequence;
	assign congestion_window    = res_out.congestion_window;
	assign slow_start_threshold = res_out.slow_start_threshold;
	assign peer_window          = res_out.peer_window;
	assign retransmit           = res_out.retransmit;
	assign rewind_bytes         = res_out.rewind_bytes;
	assign zero_window          = res_out.zero_window;

endmodule

// ===== sv/tsac_regs.sv =====
// APB configuration registers of the TCP sender engine.
module tsac_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [tsac_pkg::PADDR_W-1:0]  paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	output tsac_pkg::tsac_cfg_t           cfg
);
	import tsac_pkg::*;

	tsac_cfg_t cfg_q;
	logic      wr_en;
	tsac_reg_t reg_sel;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_sel = tsac_reg_t'(paddr[PADDR_W-1:2]);
	assign cfg     = cfg_q;

	// Register writes during the access phase.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mss           <= MSS_RESET;
			cfg_q.init_cwnd     <= CWND_RESET;
			cfg_q.init_ssthresh <= SSTHRESH_RESET;
		end else if (wr_en) begin
			unique case (reg_sel)
				REG_MSS:      cfg_q.mss           <= pwdata[15:0];
				REG_CWND:     cfg_q.init_cwnd     <= pwdata;
				REG_SSTHRESH: cfg_q.init_ssthresh <= pwdata;
				default: ;
			endcase
		end
	end

	// Read data; unmapped addresses read as zero.
	always_comb begin
		unique case (reg_sel)
			REG_MSS:      prdata = {16'd0, cfg_q.mss};
			REG_CWND:     prdata = cfg_q.init_cwnd;
			REG_SSTHRESH: prdata = cfg_q.init_ssthresh;
			default:      prdata = 32'd0;
		endcase
	end

endmodule

// ===== sv/tsac_update.sv =====
// Next-state and result logic for one request of the TCP sender engine.
module tsac_update #(
	parameter int DUP_ACK_LIMIT = tsac_pkg::DUP_ACK_LIMIT_DEF
) (
	input  tsac_pkg::tsac_state_t  st,
	input  tsac_pkg::tsac_cfg_t    cfg,
	input  logic [1:0]             operation,
	input  logic [31:0]            start_sequence,
	input  logic [31:0]            ack_value,
	input  logic [15:0]            peer_window_in,
	input  logic                   is_ack,
	output tsac_pkg::tsac_state_t  nxt,
	output tsac_pkg::tsac_result_t res
);
	import tsac_pkg::*;

	localparam logic [DUP_COUNT_W-1:0] DupLimit = DUP_COUNT_W'(DUP_ACK_LIMIT);

	logic [32:0] cwnd_sum;
	logic [32:0] dup_bound;
	logic        in_dup_range;
	logic        retx;
	logic [31:0] rewind;
	logic        zero;

	// Window growth: one MSS in slow start, else one byte, saturating.
	assign cwnd_sum = {1'b0, st.cwnd}
		+ ((st.cwnd <= st.ssthresh) ? {17'd0, cfg.mss} : 33'd1);

	// A duplicate must lie within one MSS of the send sequence, without wrap.
	assign dup_bound    = {1'b0, st.next_seq} + {17'd0, cfg.mss};
	assign in_dup_range = {1'b0, ack_value} <= dup_bound;

	always_comb begin
		nxt    = st;
		retx   = 1'b0;
		rewind = 32'd0;
		zero   = 1'b0;
		unique case (tsac_op_t'(operation))
			OP_OPEN: begin
				nxt.next_seq           = start_sequence;
				nxt.cwnd               = cfg.init_cwnd;
				nxt.ssthresh           = cfg.init_ssthresh;
				nxt.last_good_ack      = 32'd0;
				nxt.dup_count          = '0;
				nxt.last_header_ack    = 32'd0;
				nxt.last_header_window = 16'd0;
			end
			OP_HEADER: begin
				nxt.last_header_ack    = ack_value;
				nxt.last_header_window = peer_window_in;
				if (is_ack) begin
					if (ack_value > st.next_seq) begin
						nxt.next_seq      = ack_value;
						nxt.win           = peer_window_in;
						nxt.last_good_ack = ack_value;
						nxt.dup_count     = '0;
					end else if (st.dup_count >= DupLimit) begin
						// Fast retransmit: go back to the acknowledged byte.
						rewind       = st.next_seq - ack_value;
						retx         = 1'b1;
						nxt.next_seq = ack_value;
						nxt.win      = peer_window_in;
					end else if (in_dup_range && ack_value == st.last_good_ack) begin
						if (st.dup_count < DUP_COUNT_MAX) begin
							nxt.dup_count = st.dup_count + 1'b1;
						end
					end
					nxt.cwnd = cwnd_sum[32] ? 32'hFFFF_FFFF : cwnd_sum[31:0];
					zero     = (nxt.win == 16'd0);
				end
			end
			OP_TIMEOUT: begin
				nxt.ssthresh = {1'b0, st.cwnd[31:1]};
				nxt.cwnd     = {16'd0, cfg.mss};
				rewind       = st.next_seq - st.last_header_ack;
				retx         = 1'b1;
				nxt.next_seq = st.last_header_ack;
				nxt.win      = st.last_header_window;
			end
			default: ;
		endcase
	end

	// Result reports the state after the request.
	always_comb begin
		res.send_sequence        = nxt.next_seq;
		res.congestion_window    = nxt.cwnd;
		res.slow_start_threshold = nxt.ssthresh;
		res.peer_window          = nxt.win;
		res.retransmit           = retx;
		res.rewind_bytes         = rewind;
		res.zero_window          = zero;
	end

endmodule

// ===== sv/tsac_outbuf.sv =====
// Two-entry result buffer (output register plus skid register) of the TCP sender engine.
module tsac_outbuf (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  tsac_pkg::tsac_result_t push_data,
	output logic                   space,
	output logic                   result_valid,
	input  logic                   result_ready,
	output tsac_pkg::tsac_result_t result_data
);
	import tsac_pkg::*;

	tsac_result_t data_q;
	tsac_result_t skid_q;
	logic         valid_q;
	logic         skid_valid_q;
	logic         main_free;

	assign space        = !skid_valid_q;
	assign result_valid = valid_q;
	assign result_data  = data_q;
	assign main_free    = !valid_q || result_ready;

	// Occupancy of the output and skid slots.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q      <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (main_free) begin
			valid_q      <= skid_valid_q || push;
			skid_valid_q <= 1'b0;
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	// Result payload moves; the skid entry drains first to keep order.
	always_ff @(posedge clk) begin
		if (main_free) begin
			if (skid_valid_q) begin
				data_q <= skid_q;
			end else if (push) begin
				data_q <= push_data;
			end
		end else if (push) begin
			skid_q <= push_data;
		end
	end

endmodule

// ===== verif/tcp_sender_ack_congestion_tb.sv =====
// Self-checking testbench for the TCP sender acknowledgement and congestion engine.
module tcp_sender_ack_congestion_tb;
	import tsac_pkg::*;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int WATCHDOG_LIMIT   = 2000;
	localparam int REQUEST_TARGET   = 800;
	localparam int LONG_HOLD_CYCLES = 80;
	localparam int MAX_PRINTED      = 40;

	typedef enum logic [1:0] {
		RX_OPEN_FLOW,
		RX_COIN_FLIP,
		RX_EVERY_FOURTH,
		RX_RARE_STALL
	} rx_mode_t;

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;
	logic               item_valid;
	logic               item_ready;
	logic [1:0]         operation;
	logic [31:0]        start_sequence;
	logic [31:0]        ack_value;
	logic [15:0]        peer_window_in;
	logic               is_ack;
	logic               result_valid;
	logic               result_ready;
	logic [31:0]        send_sequence;
	logic [31:0]        congestion_window;
	logic [31:0]        slow_start_threshold;
	logic [15:0]        peer_window;
	logic               retransmit;
	logic [31:0]        rewind_bytes;
	logic               zero_window;

	// Shadow copies of the configuration and of the connection state.
	tsac_cfg_t    cfg_shadow;
	tsac_state_t  conn;
	tsac_result_t predicted_updates[$];

	int       error_count;
	int       requests_sent;
	int       burst_left;
	bit       sender_gaps = 1'b1;
	logic     hold_request;
	int       hold_left;
	int       rx_mode_left;
	int       rx_phase;
	rx_mode_t rx_mode;
	int       idle_count;

	tcp_sender_ack_congestion uut (.*);

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	task automatic report_error(input string msg);
		if (error_count < MAX_PRINTED)
			$display("error: %s", msg);
		error_count++;
	endtask

	// Computes the engine's state after one request and the result it reports.
	function automatic tsac_result_t advance_connection(input logic [1:0] op,
			input logic [31:0] start, input logic [31:0] ack, input logic [15:0] win,
			input logic ack_flag);
		tsac_result_t r;
		logic [32:0]  grown;
		r = '0;
		case (op)
		OP_OPEN: begin
			conn.next_seq           = start;
			conn.cwnd               = cfg_shadow.init_cwnd;
			conn.ssthresh           = cfg_shadow.init_ssthresh;
			conn.last_good_ack      = '0;
			conn.dup_count          = '0;
			conn.last_header_ack    = '0;
			conn.last_header_window = '0;
		end
		OP_HEADER: begin
			conn.last_header_ack    = ack;
			conn.last_header_window = win;
			if (ack_flag) begin
				if (ack > conn.next_seq) begin
					// Newer ack moves the send point forward.
					conn.next_seq      = ack;
					conn.win           = win;
					conn.last_good_ack = ack;
					conn.dup_count     = '0;
				end else if (conn.dup_count >= DUP_ACK_LIMIT_DEF) begin
					// Fast retransmit: go back to the acked byte.
					r.retransmit   = 1'b1;
					r.rewind_bytes = conn.next_seq - ack;
					conn.next_seq  = ack;
					conn.win       = win;
				end else if (({1'b0, ack} <= {1'b0, conn.next_seq} + {17'd0, cfg_shadow.mss})
						&& ack == conn.last_good_ack) begin
					if (conn.dup_count != DUP_COUNT_MAX)
						conn.dup_count = conn.dup_count + 1'b1;
				end
				// Slow start adds one MSS, congestion avoidance adds one byte.
				grown = {1'b0, conn.cwnd} +
					((conn.cwnd <= conn.ssthresh) ? {17'd0, cfg_shadow.mss} : 33'd1);
				conn.cwnd = grown[32] ? 32'hFFFF_FFFF : grown[31:0];
				r.zero_window = (conn.win == '0);
			end
		end
		OP_TIMEOUT: begin
			conn.ssthresh  = conn.cwnd >> 1;
			conn.cwnd      = {16'd0, cfg_shadow.mss};
			r.retransmit   = 1'b1;
			r.rewind_bytes = conn.next_seq - conn.last_header_ack;
			conn.next_seq  = conn.last_header_ack;
			conn.win       = conn.last_header_window;
		end
		default: ;
		endcase
		r.send_sequence        = conn.next_seq;
		r.congestion_window    = conn.cwnd;
		r.slow_start_threshold = conn.ssthresh;
		r.peer_window          = conn.win;
		return r;
	endfunction

	// Offers one request, with a random gap between bursts when sender_gaps is set, and records its prediction.
	task automatic send_request(input logic [1:0] op, input logic [31:0] start,
			input logic [31:0] ack, input logic [15:0] win, input logic ack_flag);
		if (sender_gaps) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 24);
				item_valid <= 1'b0;
				repeat ($urandom_range(1, 10)) @(posedge clk);
			end
			burst_left--;
		end
		item_valid     <= 1'b1;
		operation      <= op;
		start_sequence <= start;
		ack_value      <= ack;
		peer_window_in <= win;
		is_ack         <= ack_flag;
		do @(posedge clk); while (!item_ready);
		predicted_updates.push_back(advance_connection(op, start, ack, win, ack_flag));
		requests_sent++;
	endtask

	// Holds off new requests until every predicted result has been seen.
	task automatic wait_for_drain();
		item_valid <= 1'b0;
		while (predicted_updates.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_register(input tsac_reg_t idx, input logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		case (idx)
		REG_MSS:      cfg_shadow.mss = value[15:0];
		REG_CWND:     cfg_shadow.init_cwnd = value;
		REG_SSTHRESH: cfg_shadow.init_ssthresh = value;
		default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic apply_settings(input logic [15:0] mss, input logic [31:0] cwnd,
			input logic [31:0] ssthresh);
		write_register(REG_MSS, {16'd0, mss});
		write_register(REG_CWND, cwnd);
		write_register(REG_SSTHRESH, ssthresh);
	endtask

	// Zero and full windows turn up often, the rest is uniform.
	function automatic logic [15:0] random_window();
		case ($urandom_range(0, 9))
		0: return 16'h0000;
		1: return 16'hFFFF;
		default: return 16'($urandom);
		endcase
	endfunction

	// Picks a register value from 1 to top, favoring both ends.
	function automatic logic [31:0] pick_register_value(input logic [31:0] top);
		case ($urandom_range(0, 4))
		0: return 32'd1;
		1: return top;
		default: return $urandom_range(1, top);
		endcase
	endfunction

	// One connection: an open followed by a mix of acks, repeats, headers and timeouts.
	task automatic run_connection(input int events);
		int          kind;
		logic [31:0] start;
		case ($urandom_range(0, 3))
		0: start = 32'd0;
		1: start = 32'hFFFF_FFFF - $urandom_range(0, 200000);
		default: start = $urandom;
		endcase
		send_request(OP_OPEN, start, $urandom, random_window(), 1'($urandom));
		for (int i = 0; i < events; i++) begin
			kind = $urandom_range(0, 99);
			if (kind < 30) begin
				send_request(OP_HEADER, $urandom,
					conn.next_seq + $urandom_range(1, 3 * cfg_shadow.mss), random_window(), 1'b1);
			end else if (kind < 45) begin
				// Repeated acks that reach the duplicate limit, then an older ack.
				repeat ($urandom_range(3, 6))
					send_request(OP_HEADER, $urandom, conn.last_good_ack, random_window(), 1'b1);
				send_request(OP_HEADER, $urandom, conn.next_seq - $urandom_range(0, 3000),
					random_window(), 1'b1);
			end else if (kind < 55) begin
				send_request(OP_HEADER, $urandom, conn.last_good_ack, random_window(), 1'b1);
			end else if (kind < 63) begin
				send_request(OP_HEADER, $urandom, conn.next_seq - $urandom_range(0, 70000),
					random_window(), 1'b1);
			end else if (kind < 73) begin
				send_request(OP_HEADER, $urandom, conn.next_seq - $urandom_range(0, 5000),
					random_window(), 1'b0);
			end else if (kind < 78) begin
				send_request(2'($urandom_range(0, 3)), $urandom, $urandom, 16'($urandom),
					1'($urandom));
			end else if (kind < 90) begin
				send_request(OP_TIMEOUT, $urandom, $urandom, 16'($urandom), 1'($urandom));
			end else if (kind < 94) begin
				send_request(OP_UNUSED, $urandom, $urandom, 16'($urandom), 1'($urandom));
			end else if (kind < 97) begin
				send_request(OP_OPEN, $urandom, $urandom, 16'($urandom), 1'($urandom));
			end else begin
				send_request(OP_HEADER, $urandom, $urandom, random_window(), 1'b1);
			end
		end
	endtask

	// Boundary sequences under the reset configuration.
	task automatic test_directed_cases();
		// A header and a timeout before any open act on the all-zero state.
		send_request(OP_HEADER, 32'd0, 32'd0, 16'h0000, 1'b1);
		send_request(OP_TIMEOUT, 32'd0, 32'd0, 16'h0000, 1'b0);
		send_request(OP_OPEN, 32'hFFFF_FF00, 32'hFFFF_FFFF, 16'hFFFF, 1'b1);
		send_request(OP_HEADER, 32'd0, 32'hFFFF_FFFF, 16'hFFFF, 1'b1);
		// Three duplicates, then fast retransmits while the count stays saturated.
		repeat (3) send_request(OP_HEADER, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 1'b1);
		send_request(OP_HEADER, 32'd0, 32'hFFFF_FFFF, 16'h8000, 1'b1);
		send_request(OP_HEADER, 32'd0, 32'hFFFF_F000, 16'h1234, 1'b1);
		send_request(OP_HEADER, 32'd0, 32'hFFFF_E000, 16'h0000, 1'b1);
		// A non-ACK header is only recorded; the timeout rewinds to it.
		send_request(OP_HEADER, 32'd0, 32'h0000_1234, 16'h0055, 1'b0);
		send_request(OP_TIMEOUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 1'b1);
		send_request(OP_HEADER, 32'd0, 32'h0000_1235, 16'h0000, 1'b1);
		send_request(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 1'b1);
		// Open at the top of the sequence space; a zero ack counts as a duplicate.
		send_request(OP_OPEN, 32'hFFFF_FFFF, 32'd0, 16'h0000, 1'b0);
		send_request(OP_HEADER, 32'd0, 32'd0, 16'hFFFF, 1'b1);
		send_request(OP_HEADER, 32'd0, 32'd0, 16'h8000, 1'b0);
		send_request(OP_TIMEOUT, 32'd0, 32'd0, 16'h0000, 1'b0);
		send_request(OP_OPEN, 32'd0, 32'hFFFF_FFFF, 16'hFFFF, 1'b1);
		send_request(OP_HEADER, 32'd0, 32'd1, 16'h0001, 1'b1);
		send_request(OP_TIMEOUT, 32'd0, 32'd0, 16'h0000, 1'b0);
	endtask

	// Smallest and largest settings, including window growth into saturation.
	task automatic test_config_extremes();
		wait_for_drain();
		apply_settings(16'd1, 32'd1, 32'd1);
		run_connection(20);
		wait_for_drain();
		apply_settings(16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		run_connection(20);
		wait_for_drain();
		apply_settings(16'hFFFF, 32'hFFF0_0000, 32'hFFFF_FFFF);
		run_connection(40);
		wait_for_drain();
		apply_settings(MSS_RESET, 32'hFFFF_FFF0, 32'd1);
		run_connection(30);
		wait_for_drain();
		apply_settings(MSS_RESET, CWND_RESET, SSTHRESH_RESET);
	endtask

	// The result side holds off long enough that the block stalls its request side.
	task automatic test_full_buffer_stall();
		wait_for_drain();
		sender_gaps  = 1'b0;
		hold_request <= 1'b1;
		run_connection(20);
		sender_gaps = 1'b1;
		wait_for_drain();
	endtask

	task automatic test_random_connections();
		while (requests_sent < REQUEST_TARGET) begin
			if ($urandom_range(0, 7) == 0) begin
				wait_for_drain();
				apply_settings(16'(pick_register_value(32'h0000_FFFF)),
					pick_register_value(32'hFFFF_FFFF), pick_register_value(32'hFFFF_FFFF));
			end else if ($urandom_range(0, 3) == 0) begin
				wait_for_drain();
			end
			sender_gaps = ($urandom_range(0, 3) != 0);
			run_connection($urandom_range(5, 40));
		end
	endtask

	// Reset, the tests in turn, and the final verdict.
	initial begin
		arst_n         <= 1'b0;
		psel           <= 1'b0;
		penable        <= 1'b0;
		pwrite         <= 1'b0;
		paddr          <= '0;
		pwdata         <= '0;
		item_valid     <= 1'b0;
		operation      <= OP_OPEN;
		start_sequence <= '0;
		ack_value      <= '0;
		peer_window_in <= '0;
		is_ack         <= 1'b0;
		result_ready   <= 1'b0;
		hold_request   <= 1'b0;
		conn       = '0;
		cfg_shadow = '{mss: MSS_RESET, init_cwnd: CWND_RESET, init_ssthresh: SSTHRESH_RESET};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_cases();
		test_config_extremes();
		test_full_buffer_stall();
		test_random_connections();
		wait_for_drain();
		repeat (4) @(posedge clk);
		if (predicted_updates.size() != 0)
			report_error("results still outstanding at end of run");
		if (error_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// Result side: a long hold on request, otherwise a changing stall pattern.
	always @(posedge clk) begin
		if (hold_request) begin
			hold_request <= 1'b0;
			hold_left = LONG_HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			result_ready <= 1'b0;
		end else begin
			if (rx_mode_left == 0) begin
				rx_mode      = rx_mode_t'($urandom_range(0, 3));
				rx_mode_left = $urandom_range(20, 200);
			end
			rx_mode_left--;
			rx_phase++;
			case (rx_mode)
			RX_OPEN_FLOW:    result_ready <= 1'b1;
			RX_COIN_FLIP:    result_ready <= 1'($urandom);
			RX_EVERY_FOURTH: result_ready <= (rx_phase % 4) != 0;
			default:         result_ready <= ($urandom_range(0, 7) != 0);
			endcase
		end
	end

	// Compares each accepted result with the oldest prediction.
	always @(posedge clk) begin : result_checker
		tsac_result_t want;
		if (arst_n && result_valid && result_ready) begin
			if (predicted_updates.size() == 0) begin
				report_error("result arrived with no request outstanding");
			end else begin
				want = predicted_updates.pop_front();
				if (send_sequence !== want.send_sequence)
					report_error($sformatf("send_sequence %h, expected %h",
						send_sequence, want.send_sequence));
				if (congestion_window !== want.congestion_window)
					report_error($sformatf("congestion_window %h, expected %h",
						congestion_window, want.congestion_window));
				if (slow_start_threshold !== want.slow_start_threshold)
					report_error($sformatf("slow_start_threshold %h, expected %h",
						slow_start_threshold, want.slow_start_threshold));
				if (peer_window !== want.peer_window)
					report_error($sformatf("peer_window %h, expected %h",
						peer_window, want.peer_window));
				if (retransmit !== want.retransmit)
					report_error($sformatf("retransmit %b, expected %b",
						retransmit, want.retransmit));
				if (rewind_bytes !== want.rewind_bytes)
					report_error($sformatf("rewind_bytes %h, expected %h",
						rewind_bytes, want.rewind_bytes));
				if (zero_window !== want.zero_window)
					report_error($sformatf("zero_window %b, expected %b",
						zero_window, want.zero_window));
			end
		end
	end

	// Ends the run when nothing has moved for too long.
	always @(posedge clk) begin
		if ((item_valid && item_ready) || (result_valid && result_ready) || psel) begin
			idle_count = 0;
		end else begin
			idle_count++;
			if (idle_count >= WATCHDOG_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

endmodule
